FILE: rtl/lmht_pkg.sv
// ----------------------------------------------------------------------------
// lmht_pkg
// Types and constants shared by the latency metric hysteresis trigger.
// ----------------------------------------------------------------------------
package lmht_pkg;

   localparam int JITTER_W   = 20;
   localparam int COUNT_W    = 16;
   localparam int NOW_W      = 32;
   localparam int COOL_W     = 32;
   localparam int STREAK_W   = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

   localparam logic [JITTER_W-1:0] JITTER_TRIG_RST  = 20'd5000;
   localparam logic [JITTER_W-1:0] JITTER_REL_RST   = 20'd3000;
   localparam logic [COUNT_W-1:0]  SPIKE_TRIG_RST   = 16'd3;
   localparam logic [COUNT_W-1:0]  SPIKE_REL_RST    = 16'd1;
   localparam logic [COUNT_W-1:0]  MIGR_TRIG_RST    = 16'd1;
   localparam logic [COOL_W-1:0]   RESTRICT_COOL_RST = 32'd10000;
   localparam logic [COOL_W-1:0]   REPIN_COOL_RST    = 32'd3000;
   localparam logic [COOL_W-1:0]   STICKY_COOL_RST   = 32'd5000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JITTER_TRIG   = 3'd0,
      CSR_JITTER_REL    = 3'd1,
      CSR_SPIKE_TRIG    = 3'd2,
      CSR_SPIKE_REL     = 3'd3,
      CSR_MIGR_TRIG     = 3'd4,
      CSR_RESTRICT_COOL = 3'd5,
      CSR_REPIN_COOL    = 3'd6,
      CSR_STICKY_COOL   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [JITTER_W-1:0] jitter_us;
      logic [COUNT_W-1:0]  spike_count;
      logic [COUNT_W-1:0]  migration_count;
      logic                affinity_ok;
      logic [NOW_W-1:0]    now_ms;
   } req_word_type;

   typedef struct packed {
      logic restrict_up;
      logic repin_cmd;
      logic sticky_cmd;
      logic restrict_active;
      logic repin_active;
      logic sticky_active;
   } rsp_word_type;

   typedef struct packed {
      logic step;
      logic above;
      logic release_hit;
      logic fire_allow;
   } chan_ctl_type;

   typedef struct packed {
      logic cmd;
      logic active;
   } chan_stat_type;

endpackage

FILE: rtl/lmht_if.sv
// ----------------------------------------------------------------------------
// lmht_req_if / lmht_rsp_if
// Valid/ready channels carrying metric samples and trigger results.
// ----------------------------------------------------------------------------
interface lmht_req_if;
   logic                  valid;
   logic                  ready;
   lmht_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lmht_rsp_if;
   logic                  valid;
   logic                  ready;
   lmht_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lmht_chan.sv
// ----------------------------------------------------------------------------
// lmht_chan
// One hysteresis channel: saturating streak, debounce, cooldown, active flag.
// ----------------------------------------------------------------------------
module lmht_chan #(
   parameter int DEBOUNCE_CYCLES = 3,
   parameter int TIME_BITS       = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lmht_pkg::chan_ctl_type            ctl,
   input  logic [TIME_BITS-1:0]              now,
   input  logic [lmht_pkg::COOL_W-1:0]       cooldown,
   output lmht_pkg::chan_stat_type           stat
);

   localparam int CMP_W = (TIME_BITS > lmht_pkg::COOL_W) ? TIME_BITS : lmht_pkg::COOL_W;

   logic [lmht_pkg::STREAK_W-1:0] streak_ff, streak_in, streak_bump;
   logic                          flag_ff, flag_in;
   logic [TIME_BITS-1:0]          last_ff, last_in, elapsed_t;
   logic                          emitted_ff, emitted_in;
   logic                          cool_done, fire;

   always_comb begin
      streak_bump = (streak_ff == lmht_pkg::STREAK_MAX) ? streak_ff
                                                         : streak_ff + 1'b1;
      elapsed_t   = now - last_ff;
      cool_done   = !emitted_ff || (CMP_W'(elapsed_t) >= CMP_W'(cooldown));
      fire        = ctl.above && ctl.fire_allow && cool_done
                 && (streak_bump >= lmht_pkg::STREAK_W'(DEBOUNCE_CYCLES));
      streak_in   = streak_ff;
      flag_in     = flag_ff;
      last_in     = last_ff;
      emitted_in  = emitted_ff;
      priority if (ctl.above) begin
         streak_in = streak_bump;
         if (fire) begin
            flag_in    = 1'b1;
            last_in    = now;
            emitted_in = 1'b1;
         end
      end else if (ctl.release_hit) begin
         streak_in = '0;
         flag_in   = 1'b0;
      end else begin
         streak_in = streak_ff;
      end
      stat.cmd    = fire;
      stat.active = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff  <= '0;
         flag_ff    <= 1'b0;
         last_ff    <= '0;
         emitted_ff <= 1'b0;
      end else if (ctl.step) begin
         streak_ff  <= streak_in;
         flag_ff    <= flag_in;
         last_ff    <= last_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

FILE: rtl/latency_metric_hysteresis_trigger.sv
// ----------------------------------------------------------------------------
// latency_metric_hysteresis_trigger
// Three hysteresis channels (restrict, repin, sticky) driven by one metric
// sample per word, with debounce and per-channel cooldown.
//
//   port       dir   handshake      word
//   req_chan   in    valid/ready    jitter, spikes, migrations, affinity, time
//   rsp_chan   out   valid/ready    three command pulses, three active flags
//   csr_*      in    write enable   index 0..7, data up to 32 bits
//
// One word per cycle sustained while the sink takes results; each word passes
// through the input register, then the result register. The channel state
// updates as a word moves from the input register to the result register.
// A stalled result holds the input register; ready falls only when both
// registers are full and the sink is not taking. Synchronous reset clears
// the valid flags and channel state and loads the register defaults.
// ----------------------------------------------------------------------------
module latency_metric_hysteresis_trigger #(
   parameter int DEBOUNCE_CYCLES = 3,
   parameter int TIME_BITS       = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lmht_req_if.sink                             req_chan,
   lmht_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [lmht_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lmht_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [lmht_pkg::JITTER_W-1:0] jitter_trig_ff, jitter_rel_ff;
   logic [lmht_pkg::COUNT_W-1:0]  spike_trig_ff, spike_rel_ff, migr_trig_ff;
   logic [lmht_pkg::COOL_W-1:0]   restrict_cool_ff, repin_cool_ff, sticky_cool_ff;

   logic                   in_valid_ff;
   lmht_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   lmht_pkg::rsp_word_type out_word_ff, out_word_in;

   logic                    advance;
   logic [TIME_BITS-1:0]    now_t;
   lmht_pkg::chan_ctl_type  restrict_ctl, repin_ctl, sticky_ctl;
   lmht_pkg::chan_stat_type restrict_stat, repin_stat, sticky_stat;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         jitter_trig_ff   <= lmht_pkg::JITTER_TRIG_RST;
         jitter_rel_ff    <= lmht_pkg::JITTER_REL_RST;
         spike_trig_ff    <= lmht_pkg::SPIKE_TRIG_RST;
         spike_rel_ff     <= lmht_pkg::SPIKE_REL_RST;
         migr_trig_ff     <= lmht_pkg::MIGR_TRIG_RST;
         restrict_cool_ff <= lmht_pkg::RESTRICT_COOL_RST;
         repin_cool_ff    <= lmht_pkg::REPIN_COOL_RST;
         sticky_cool_ff   <= lmht_pkg::STICKY_COOL_RST;
      end else if (csr_we) begin
         unique case (lmht_pkg::csr_index_type'(csr_index))
            lmht_pkg::CSR_JITTER_TRIG:   jitter_trig_ff   <= csr_wdata[lmht_pkg::JITTER_W-1:0];
            lmht_pkg::CSR_JITTER_REL:    jitter_rel_ff    <= csr_wdata[lmht_pkg::JITTER_W-1:0];
            lmht_pkg::CSR_SPIKE_TRIG:    spike_trig_ff    <= csr_wdata[lmht_pkg::COUNT_W-1:0];
            lmht_pkg::CSR_SPIKE_REL:     spike_rel_ff     <= csr_wdata[lmht_pkg::COUNT_W-1:0];
            lmht_pkg::CSR_MIGR_TRIG:     migr_trig_ff     <= csr_wdata[lmht_pkg::COUNT_W-1:0];
            lmht_pkg::CSR_RESTRICT_COOL: restrict_cool_ff <= csr_wdata[lmht_pkg::COOL_W-1:0];
            lmht_pkg::CSR_REPIN_COOL:    repin_cool_ff    <= csr_wdata[lmht_pkg::COOL_W-1:0];
            lmht_pkg::CSR_STICKY_COOL:   sticky_cool_ff   <= csr_wdata[lmht_pkg::COOL_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the input word into the result register when it is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_word_ff <= req_chan.data;
      end
   end

   assign now_t = TIME_BITS'(in_word_ff.now_ms);

   always_comb begin
      restrict_ctl.step        = advance;
      restrict_ctl.above       = in_word_ff.jitter_us > jitter_trig_ff;
      restrict_ctl.release_hit = in_word_ff.jitter_us < jitter_rel_ff;
      restrict_ctl.fire_allow  = 1'b1;

      repin_ctl.step           = advance;
      repin_ctl.above          = in_word_ff.spike_count > spike_trig_ff;
      repin_ctl.release_hit    = in_word_ff.spike_count <= spike_rel_ff;
      repin_ctl.fire_allow     = in_word_ff.affinity_ok;

      sticky_ctl.step          = advance;
      sticky_ctl.above         = in_word_ff.migration_count > migr_trig_ff;
      sticky_ctl.release_hit   = in_word_ff.migration_count == '0;
      sticky_ctl.fire_allow    = 1'b1;
   end

   lmht_chan #(.DEBOUNCE_CYCLES(DEBOUNCE_CYCLES), .TIME_BITS(TIME_BITS)) u_restrict (
      .clock    (clock),
      .reset    (reset),
      .ctl      (restrict_ctl),
      .now      (now_t),
      .cooldown (restrict_cool_ff),
      .stat     (restrict_stat)
   );

   lmht_chan #(.DEBOUNCE_CYCLES(DEBOUNCE_CYCLES), .TIME_BITS(TIME_BITS)) u_repin (
      .clock    (clock),
      .reset    (reset),
      .ctl      (repin_ctl),
      .now      (now_t),
      .cooldown (repin_cool_ff),
      .stat     (repin_stat)
   );

   lmht_chan #(.DEBOUNCE_CYCLES(DEBOUNCE_CYCLES), .TIME_BITS(TIME_BITS)) u_sticky (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sticky_ctl),
      .now      (now_t),
      .cooldown (sticky_cool_ff),
      .stat     (sticky_stat)
   );

   always_comb begin
      out_word_in.restrict_up     = restrict_stat.cmd;
      out_word_in.repin_cmd       = repin_stat.cmd;
      out_word_in.sticky_cmd      = sticky_stat.cmd;
      out_word_in.restrict_active = restrict_stat.active;
      out_word_in.repin_active    = repin_stat.active;
      out_word_in.sticky_active   = sticky_stat.active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

endmodule
